/* design/sha1sh_pkg.sv */
// Shared types, constants and round functions for the SHA-1 stream hasher.
package sha1sh_pkg;

   // Input word: command and message byte
   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_word_type;

   // Result word: one digest word and its last marker
   typedef struct packed {
      logic [31:0] digest_word;
      logic        last_word;
   } rsp_word_type;

   // Classified word handed from the front queue to the engine
   typedef struct packed {
      logic       finish;
      logic [7:0] data_byte;
   } cmd_word_type;

   // Command codes
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // Front queue depth
   localparam int QUEUE_DEPTH = 4;

   // Chaining word initial values
   localparam logic [31:0] INIT_H0 = 32'h67452301;
   localparam logic [31:0] INIT_H1 = 32'hefcdab89;
   localparam logic [31:0] INIT_H2 = 32'h98badcfe;
   localparam logic [31:0] INIT_H3 = 32'h10325476;
   localparam logic [31:0] INIT_H4 = 32'hc3d2e1f0;

   // Round constants
   localparam logic [31:0] ROUND_K0 = 32'h5a827999;
   localparam logic [31:0] ROUND_K1 = 32'h6ed9eba1;
   localparam logic [31:0] ROUND_K2 = 32'h8f1bbcdc;
   localparam logic [31:0] ROUND_K3 = 32'hca62c1d6;

   // Padding marker byte
   localparam logic [7:0] PAD_MARK = 8'h80;

   // Fill position where the length field starts
   localparam logic [5:0] LEN_POS = 6'd56;

   // Index of the last round in a block (rounds 0 to 79)
   localparam logic [6:0] LAST_ROUND = 7'd79;

   // Mixing function for a given round
   function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd >= 7'd40 && rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   // Additive constant for a given round
   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20) begin
         k = ROUND_K0;
      end else if (rnd < 7'd40) begin
         k = ROUND_K1;
      end else if (rnd < 7'd60) begin
         k = ROUND_K2;
      end else begin
         k = ROUND_K3;
      end
      return k;
   endfunction

endpackage

/* design/sha1sh_front.sv */
// Front queue: takes input words and hands them on classified to the engine.
module sha1sh_front #(
   parameter int Depth = sha1sh_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sha1sh_pkg::req_word_type  push_word,
   output logic                      full,
   output logic                      q_valid,
   output sha1sh_pkg::cmd_word_type  q_word,
   input  logic                      q_pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   sha1sh_pkg::req_word_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            push_ok;
   logic            pop_ok;
   sha1sh_pkg::req_word_type head;

   assign full    = (cnt_ff == FullCnt);
   assign q_valid = (cnt_ff != '0);
   assign push_ok = push && !full;
   assign pop_ok  = q_pop && q_valid;

   // Classify the oldest word
   assign head             = mem_ff[rd_ptr_ff];
   assign q_word.finish    = (head.command == sha1sh_pkg::CMD_FINISH);
   assign q_word.data_byte = head.data_byte;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* design/sha1sh_back.sv */
// Hash engine: block buffer, padding sequencer, 80-round compression, digest output.
module sha1sh_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  sha1sh_pkg::cmd_word_type  q_word,
   output logic                      q_pop,
   output logic                      rsp_empty,
   output sha1sh_pkg::rsp_word_type  rsp_word,
   input  logic                      rsp_pop
);

   // Engine states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   // Padding phases
   localparam logic [1:0] PH_MARK = 2'd0;
   localparam logic [1:0] PH_ZERO = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [2:0] LAST_LEN  = 3'd7;
   localparam logic [2:0] LAST_EMIT = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [511:0] buf_ff, buf_in;
   logic [63:0]  bitcnt_ff, bitcnt_in;
   logic [5:0]   fill_ff, fill_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic [1:0]   phase_ff, phase_in;
   logic [2:0]   len_idx_ff, len_idx_in;
   logic [2:0]   emit_idx_ff, emit_idx_in;
   logic         finish_ff, finish_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [31:0]  chain_ff [5];
   logic [31:0]  chain_in [5];

   logic         shift_en;
   logic [7:0]   shift_byte;
   logic [7:0]   len_byte;
   logic [31:0]  w0, w2, w8, w13, w_mix, w_next, t_sum;

   // Schedule window taps
   assign w0     = buf_ff[511:480];
   assign w2     = buf_ff[447:416];
   assign w8     = buf_ff[255:224];
   assign w13    = buf_ff[95:64];
   assign w_mix  = w13 ^ w8 ^ w2 ^ w0;
   assign w_next = {w_mix[30:0], w_mix[31]};

   // Round sum
   assign t_sum = {a_ff[26:0], a_ff[31:27]} + sha1sh_pkg::round_f(rnd_ff, b_ff, c_ff, d_ff)
                  + e_ff + w0 + sha1sh_pkg::round_k(rnd_ff);

   // Length byte, most significant first
   assign len_byte = bitcnt_ff[{LAST_LEN - len_idx_ff, 3'b000} +: 8];

   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign rsp_empty = (state_ff != ST_EMIT);
   assign rsp_word.digest_word = chain_ff[emit_idx_ff];
   assign rsp_word.last_word   = (emit_idx_ff == LAST_EMIT);

   always_comb begin
      state_in    = state_ff;
      buf_in      = buf_ff;
      bitcnt_in   = bitcnt_ff;
      fill_in     = fill_ff;
      rnd_in      = rnd_ff;
      phase_in    = phase_ff;
      len_idx_in  = len_idx_ff;
      emit_idx_in = emit_idx_ff;
      finish_in   = finish_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      for (int i = 0; i < 5; i++) begin
         chain_in[i] = chain_ff[i];
      end
      shift_en   = 1'b0;
      shift_byte = '0;

      case (state_ff)
         // Take a word: append a byte or start padding
         ST_IDLE: begin
            if (q_valid) begin
               if (q_word.finish) begin
                  finish_in  = 1'b1;
                  phase_in   = PH_MARK;
                  len_idx_in = '0;
                  state_in   = ST_PAD;
               end else begin
                  shift_en   = 1'b1;
                  shift_byte = q_word.data_byte;
                  bitcnt_in  = bitcnt_ff + 64'd8;
               end
            end
         end
         // Feed padding bytes into the buffer
         ST_PAD: begin
            case (phase_ff)
               PH_MARK: begin
                  shift_en   = 1'b1;
                  shift_byte = sha1sh_pkg::PAD_MARK;
                  phase_in   = PH_ZERO;
               end
               PH_ZERO: begin
                  if (fill_ff == sha1sh_pkg::LEN_POS) begin
                     phase_in = PH_LEN;
                  end else begin
                     shift_en   = 1'b1;
                     shift_byte = '0;
                  end
               end
               PH_LEN: begin
                  shift_en   = 1'b1;
                  shift_byte = len_byte;
                  len_idx_in = len_idx_ff + 1'b1;
                  if (len_idx_ff == LAST_LEN) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  state_in = ST_EMIT;
               end
            endcase
         end
         // Run one round and slide the schedule window
         ST_ROUND: begin
            e_in   = d_ff;
            d_in   = c_ff;
            c_in   = {b_ff[1:0], b_ff[31:2]};
            b_in   = a_ff;
            a_in   = t_sum;
            buf_in = {buf_ff[479:0], w_next};
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == sha1sh_pkg::LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         // Fold the working words into the chain
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            if (!finish_ff) begin
               state_in = ST_IDLE;
            end else if (phase_ff == PH_DONE) begin
               state_in    = ST_EMIT;
               emit_idx_in = '0;
            end else begin
               state_in = ST_PAD;
            end
         end
         // Hand out digest words, then reinitialize
         ST_EMIT: begin
            if (rsp_pop) begin
               if (emit_idx_ff == LAST_EMIT) begin
                  emit_idx_in = '0;
                  finish_in   = 1'b0;
                  bitcnt_in   = '0;
                  fill_in     = '0;
                  chain_in[0] = sha1sh_pkg::INIT_H0;
                  chain_in[1] = sha1sh_pkg::INIT_H1;
                  chain_in[2] = sha1sh_pkg::INIT_H2;
                  chain_in[3] = sha1sh_pkg::INIT_H3;
                  chain_in[4] = sha1sh_pkg::INIT_H4;
                  state_in    = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Shift a byte in; start compression on a full block
      if (shift_en) begin
         buf_in  = {buf_ff[503:0], shift_byte};
         fill_in = fill_ff + 1'b1;
         if (fill_ff == LAST_FILL) begin
            state_in = ST_ROUND;
            rnd_in   = '0;
            a_in     = chain_ff[0];
            b_in     = chain_ff[1];
            c_in     = chain_ff[2];
            d_in     = chain_ff[3];
            e_in     = chain_ff[4];
         end
      end
   end

   // Control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         bitcnt_ff   <= '0;
         fill_ff     <= '0;
         rnd_ff      <= '0;
         phase_ff    <= PH_MARK;
         len_idx_ff  <= '0;
         emit_idx_ff <= '0;
         finish_ff   <= 1'b0;
         chain_ff[0] <= sha1sh_pkg::INIT_H0;
         chain_ff[1] <= sha1sh_pkg::INIT_H1;
         chain_ff[2] <= sha1sh_pkg::INIT_H2;
         chain_ff[3] <= sha1sh_pkg::INIT_H3;
         chain_ff[4] <= sha1sh_pkg::INIT_H4;
      end else begin
         state_ff    <= state_in;
         bitcnt_ff   <= bitcnt_in;
         fill_ff     <= fill_in;
         rnd_ff      <= rnd_in;
         phase_ff    <= phase_in;
         len_idx_ff  <= len_idx_in;
         emit_idx_ff <= emit_idx_in;
         finish_ff   <= finish_in;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   // Block buffer and working words
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

endmodule

/* design/sha1_stream_hash_top.sv */
// Each byte is appended into the block buffer; each full 64-byte block adds 80 rounds and one fold.
// The engine takes no new byte while a block is compressed: a single shared round unit runs all rounds.
// Finish: the engine pads (a second block if the length does not fit) and compresses,
// then one digest word per pop, five in all; the next message starts after the fifth.
// Synchronous reset clears queue, counters and chaining words;
// the block buffer is not cleared.
module sha1_stream_hash_top #(
   parameter int QueueDepth = sha1sh_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sha1sh_pkg::req_word_type req_word,
   output logic                     full,
   output logic                     empty,
   output sha1sh_pkg::rsp_word_type rsp_word,
   input  logic                     pop
);

   logic                     q_valid;
   logic                     q_pop;
   sha1sh_pkg::cmd_word_type q_word;

   // Accept and classify words
   sha1sh_front #(
      .Depth(QueueDepth)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_word(req_word),
      .full     (full),
      .q_valid  (q_valid),
      .q_word   (q_word),
      .q_pop    (q_pop)
   );

   // Hash and emit digests
   sha1sh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_word   (q_word),
      .q_pop    (q_pop),
      .rsp_empty(empty),
      .rsp_word (rsp_word),
      .rsp_pop  (pop)
   );

   // Engine drains the queue only while no digest is pending
   assert property (@(posedge clock) disable iff (reset) q_pop |-> empty)
      else $error("queue drained while digest pending");

   // A full queue always offers a word to the engine
   assert property (@(posedge clock) disable iff (reset) full |-> q_valid)
      else $error("queue full but no word offered");

   // Taking the last digest word ends the digest
   assert property (@(posedge clock) disable iff (reset)
                    (pop && !empty && rsp_word.last_word) |=> empty)
      else $error("digest continues after last word");

endmodule
